FILE: rtl/fbh_pkg.sv
// Shared types and constants for the five-bin histogram with mean.
// Used by every module of the block; depends on nothing else.
package fbh_pkg;

    localparam int NUM_BINS       = 5;
    localparam int NUM_BORDERS    = 6;
    localparam int BORDER_W       = 16;
    localparam int SAMPLE_W       = 16;
    localparam int BIN_IDX_W      = 3;
    localparam int BIN_CNT_W      = 16;
    localparam int MEAN_W         = 24;
    localparam int FRAC_BITS      = 8;
    localparam int SUM_W          = 32;
    localparam int DVD_W          = SUM_W + FRAC_BITS;
    localparam int STEP_W         = $clog2(DVD_W + 1);
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;
    localparam int REG_IDX_W      = 3;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 48;

    localparam int VALUE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    typedef logic [NUM_BORDERS-1:0][BORDER_W-1:0] border_arr_t;

    localparam border_arr_t BORDER_RESET = {16'd120, 16'd80, 16'd65, 16'd50, 16'd35, 16'd20};

    typedef enum logic [1:0] {
        ST_ACC,
        ST_START,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic acc_en;
        logic div_start;
        logic out_load;
        logic clear;
    } fbh_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
        logic emit_last;
    } fbh_sts_t;

endpackage

FILE: rtl/fbh_regs.sv
// APB register file holding the six bin borders.
// Depends on fbh_pkg for widths and reset values.
module fbh_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbh_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [fbh_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fbh_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output fbh_pkg::border_arr_t                borders
);

    fbh_pkg::border_arr_t                border_reg;
    fbh_pkg::border_arr_t                border_next;
    logic [fbh_pkg::REG_IDX_W-1:0]       reg_idx;
    logic                                wr_en;

    assign reg_idx = paddr[fbh_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign borders = border_reg;

    always_comb
    begin
        border_next = border_reg;
        for (int i = 0; i < fbh_pkg::NUM_BORDERS; i++)
        begin
            if (wr_en && (reg_idx == fbh_pkg::REG_IDX_W'(i)))
            begin
                border_next[i] = pwdata[fbh_pkg::BORDER_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < fbh_pkg::NUM_BORDERS; i++)
        begin
            if (reg_idx == fbh_pkg::REG_IDX_W'(i))
            begin
                prdata = fbh_pkg::APB_DATA_W'(border_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg <= fbh_pkg::BORDER_RESET;
        end
        else
        begin
            border_reg <= border_next;
        end
    end

endmodule

FILE: rtl/fbh_div.sv
// Restoring divider for the set mean: one quotient bit per cycle.
// Depends on fbh_pkg; instantiated by fbh_datapath.
module fbh_div
#(
    parameter int COUNT_BITS = fbh_pkg::COUNT_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [fbh_pkg::DVD_W-1:0]       dividend,
    input  logic [COUNT_BITS-1:0]           divisor,
    output logic                            done,
    output logic [fbh_pkg::MEAN_W-1:0]      quotient
);

    logic                           busy_reg,  busy_next;
    logic                           done_reg,  done_next;
    logic [fbh_pkg::STEP_W-1:0]     step_reg,  step_next;
    logic [COUNT_BITS-1:0]          rem_reg,   rem_next;
    logic [COUNT_BITS-1:0]          dsr_reg,   dsr_next;
    logic [fbh_pkg::DVD_W-1:0]      quo_reg,   quo_next;
    logic [COUNT_BITS:0]            trial;
    logic [COUNT_BITS:0]            diff;
    logic                           fits;

    assign trial = {rem_reg, quo_reg[fbh_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = fbh_pkg::STEP_W'(fbh_pkg::DVD_W);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the low bits suffice
            rem_next  = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            quo_next  = {quo_reg[fbh_pkg::DVD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == fbh_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // saturate quotients that do not fit 16.8
    assign quotient = (quo_reg[fbh_pkg::DVD_W-1:fbh_pkg::MEAN_W] != '0)
                      ? {fbh_pkg::MEAN_W{1'b1}} : quo_reg[fbh_pkg::MEAN_W-1:0];
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

endmodule

FILE: rtl/fbh_datapath.sv
// Datapath: bin compares, saturating accumulators, mean divider and output register.
// Depends on fbh_pkg and fbh_div; driven by fbh_ctrl commands.
module fbh_datapath
#(
    parameter int VALUE_BITS = fbh_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = fbh_pkg::COUNT_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  fbh_pkg::fbh_cmd_t                   cmd,
    output fbh_pkg::fbh_sts_t                   sts,
    input  fbh_pkg::border_arr_t                borders,
    input  logic [fbh_pkg::SAMPLE_W-1:0]        sample_value,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [fbh_pkg::BIN_IDX_W-1:0]       bin_index,
    output logic [fbh_pkg::BIN_CNT_W-1:0]       bin_count,
    output logic [fbh_pkg::MEAN_W-1:0]          mean_value,
    output logic                                set_empty,
    output logic                                last_of_run
);

    localparam logic [fbh_pkg::SAMPLE_W-1:0] VAL_MASK =
        (VALUE_BITS >= fbh_pkg::SAMPLE_W) ? {fbh_pkg::SAMPLE_W{1'b1}}
        : fbh_pkg::SAMPLE_W'((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [fbh_pkg::BIN_IDX_W-1:0] LAST_BIN =
        fbh_pkg::BIN_IDX_W'(fbh_pkg::NUM_BINS - 1);

    logic [fbh_pkg::SAMPLE_W-1:0]       value;
    logic [fbh_pkg::NUM_BINS-1:0]       hit;
    logic [COUNT_BITS-1:0]              bin_cnt_reg  [fbh_pkg::NUM_BINS];
    logic [COUNT_BITS-1:0]              bin_cnt_next [fbh_pkg::NUM_BINS];
    logic [fbh_pkg::SUM_W-1:0]          sum_reg,   sum_next;
    logic [fbh_pkg::SUM_W:0]            sum_add;
    logic [COUNT_BITS-1:0]              item_cnt_reg, item_cnt_next;
    logic [fbh_pkg::BIN_IDX_W-1:0]      emit_idx_reg, emit_idx_next;
    logic [fbh_pkg::MEAN_W-1:0]         mean_reg;
    logic                               empty_reg;
    logic                               out_valid_reg, out_valid_next;
    logic [fbh_pkg::BIN_IDX_W-1:0]      out_idx_reg;
    logic [fbh_pkg::BIN_CNT_W-1:0]      out_cnt_reg;
    logic [fbh_pkg::MEAN_W-1:0]         out_mean_reg;
    logic                               out_empty_reg;
    logic                               out_last_reg;
    logic                               div_done;
    logic [fbh_pkg::MEAN_W-1:0]         div_quotient;

    assign value   = sample_value & VAL_MASK;
    assign sum_add = {1'b0, sum_reg} + (fbh_pkg::SUM_W + 1)'(value);

    always_comb
    begin
        for (int k = 0; k < fbh_pkg::NUM_BINS; k++)
        begin
            hit[k] = (value > borders[k]) && (value <= borders[k+1]);
            bin_cnt_next[k] = bin_cnt_reg[k];
            if (cmd.clear)
            begin
                bin_cnt_next[k] = '0;
            end
            else if (cmd.acc_en && hit[k] && (bin_cnt_reg[k] != COUNT_MAX))
            begin
                bin_cnt_next[k] = bin_cnt_reg[k] + 1'b1;
            end
        end
    end

    always_comb
    begin
        sum_next      = sum_reg;
        item_cnt_next = item_cnt_reg;
        if (cmd.clear)
        begin
            sum_next      = '0;
            item_cnt_next = '0;
        end
        else if (cmd.acc_en)
        begin
            sum_next = sum_add[fbh_pkg::SUM_W] ? {fbh_pkg::SUM_W{1'b1}}
                                               : sum_add[fbh_pkg::SUM_W-1:0];
            if (item_cnt_reg != COUNT_MAX)
            begin
                item_cnt_next = item_cnt_reg + 1'b1;
            end
        end
    end

    fbh_div
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({sum_reg, {fbh_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (item_cnt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        emit_idx_next = emit_idx_reg;
        if (cmd.out_load)
        begin
            emit_idx_next = (emit_idx_reg == LAST_BIN) ? '0 : emit_idx_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < fbh_pkg::NUM_BINS; k++)
            begin
                bin_cnt_reg[k] <= '0;
            end
            sum_reg       <= '0;
            item_cnt_reg  <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < fbh_pkg::NUM_BINS; k++)
            begin
                bin_cnt_reg[k] <= bin_cnt_next[k];
            end
            sum_reg       <= sum_next;
            item_cnt_reg  <= item_cnt_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            empty_reg <= (item_cnt_reg == '0);
            mean_reg  <= (item_cnt_reg == '0) ? '0 : div_quotient;
        end
        if (cmd.out_load)
        begin
            out_idx_reg   <= emit_idx_reg;
            out_cnt_reg   <= fbh_pkg::BIN_CNT_W'(bin_cnt_reg[emit_idx_reg]);
            out_mean_reg  <= mean_reg;
            out_empty_reg <= empty_reg;
            out_last_reg  <= (emit_idx_reg == LAST_BIN);
        end
    end

    assign sts.div_done  = div_done;
    assign sts.out_free  = !out_valid_reg || m_tready;
    assign sts.emit_last = (emit_idx_reg == LAST_BIN);

    assign m_tvalid    = out_valid_reg;
    assign bin_index   = out_idx_reg;
    assign bin_count   = out_cnt_reg;
    assign mean_value  = out_mean_reg;
    assign set_empty   = out_empty_reg;
    assign last_of_run = out_last_reg;

    // a bin never counts more values than the set holds
    for (genvar k = 0; k < fbh_pkg::NUM_BINS; k++)
    begin : g_bin_chk
        a_bin_le_items: assert property (@(posedge clk) disable iff (!rst_n)
            bin_cnt_reg[k] <= item_cnt_reg)
            else $error("bin count exceeds item count");
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (sum_reg == '0) && (item_cnt_reg == '0))
        else $error("accumulators not cleared after run");

    a_acc_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_en |-> !(cmd.out_load || cmd.div_start))
        else $error("item accepted while the mean is computed or reported");

endmodule

FILE: rtl/fbh_ctrl.sv
// Controller state machine: accumulate, divide, report five bins.
// Depends on fbh_pkg; issues commands to fbh_datapath.
module fbh_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tlast,
    output logic                    s_tready,
    input  fbh_pkg::fbh_sts_t       sts,
    output fbh_pkg::fbh_cmd_t       cmd
);

    fbh_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbh_pkg::ST_ACC:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = fbh_pkg::ST_START;
                end
            end
            fbh_pkg::ST_START:
            begin
                state_next = fbh_pkg::ST_DIV;
            end
            fbh_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = fbh_pkg::ST_EMIT;
                end
            end
            fbh_pkg::ST_EMIT:
            begin
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = fbh_pkg::ST_ACC;
                end
            end
            default:
            begin
                state_next = fbh_pkg::ST_ACC;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            fbh_pkg::ST_ACC:
            begin
                s_tready   = 1'b1;
                cmd.acc_en = s_tvalid;
            end
            fbh_pkg::ST_START:
            begin
                cmd.div_start = 1'b1;
            end
            fbh_pkg::ST_DIV:
            begin
                cmd = '0;
            end
            fbh_pkg::ST_EMIT:
            begin
                cmd.out_load = sts.out_free;
                // drop the accumulators as the fifth result is loaded
                cmd.clear    = sts.out_free && sts.emit_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbh_pkg::ST_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/five_bin_histogram_with_mean.sv
// Five-bin histogram with set mean. Within a set, one item is accepted every cycle; the
// item flagged by s_tlast closes the set. From that item s_tready stays low while the
// mean (sum * 256 / count, 16.8, truncated and saturated) goes through a restoring
// divider that yields one quotient bit per cycle, and then while the five results, one
// per bin, enter the output register at one per cycle as the sink takes them.
// Bin k counts values above border k and up to border k+1.
// Depends on fbh_pkg, fbh_regs, fbh_div, fbh_datapath and fbh_ctrl.
module five_bin_histogram_with_mean
#(
    parameter int VALUE_BITS = fbh_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = fbh_pkg::COUNT_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbh_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [fbh_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fbh_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fbh_pkg::S_TDATA_W-1:0]       s_tdata,   // [15:0] sample_value
    input  logic                                s_tlast,   // final_item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fbh_pkg::M_TDATA_W-1:0]       m_tdata,   // [2:0] bin_index, [18:3] bin_count,
                                                           // [42:19] mean_value, rest zero
    output logic                                m_tuser,   // set_empty
    output logic                                m_tlast    // last_of_run
);

    fbh_pkg::border_arr_t                   borders;
    fbh_pkg::fbh_cmd_t                      cmd;
    fbh_pkg::fbh_sts_t                      sts;
    logic [fbh_pkg::BIN_IDX_W-1:0]          bin_index;
    logic [fbh_pkg::BIN_CNT_W-1:0]          bin_count;
    logic [fbh_pkg::MEAN_W-1:0]             mean_value;

    fbh_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .borders (borders)
    );

    fbh_datapath
    #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .borders      (borders),
        .sample_value (s_tdata[fbh_pkg::SAMPLE_W-1:0]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .bin_index    (bin_index),
        .bin_count    (bin_count),
        .mean_value   (mean_value),
        .set_empty    (m_tuser),
        .last_of_run  (m_tlast)
    );

    fbh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign m_tdata = {
        (fbh_pkg::M_TDATA_W - fbh_pkg::MEAN_W - fbh_pkg::BIN_CNT_W - fbh_pkg::BIN_IDX_W)'(0),
        mean_value, bin_count, bin_index};

endmodule
